/* hdl/lrsb_pkg.sv */
// ----------------------------------------------------------------------------
// lrsb_pkg
// Shared constants and types for the base-256 LSD radix sorter.
// ----------------------------------------------------------------------------
`default_nettype none
package lrsb_pkg;
  localparam int MAX_N         = 64;
  localparam int MAX_KEY_BYTES = 8;
  localparam int RADIX         = 256;
  localparam int IDX_W         = $clog2(MAX_N);
  localparam int CNT_W         = $clog2(MAX_N + 1);
  localparam int KB_W          = 4;
  localparam int DIG_W         = 8;
  localparam int KEY_W         = 64;
  localparam int TAG_W         = 16;
  localparam int QDEPTH        = 2;

  localparam logic [0:0] REG_KEY_BYTES  = 1'd0;
  localparam logic [0:0] REG_DESCENDING = 1'd1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } item_t;
endpackage
`default_nettype wire

/* hdl/lrsb_front.sv */
// ----------------------------------------------------------------------------
// lrsb_front
// Input stage: a two-entry queue that takes beats and hands them on to the
// sorting core, so either side may stall without the other.
// ----------------------------------------------------------------------------
`default_nettype none
module lrsb_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire lrsb_pkg::item_t in_item,
  output logic                q_valid,
  input  wire                 q_take,
  output lrsb_pkg::item_t     q_item
);
  import lrsb_pkg::*;

  item_t     mem_r [QDEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

/* hdl/lrsb_core.sv */
// ----------------------------------------------------------------------------
// lrsb_core
// Loads items into ping-pong stores, runs one counting-sort pass per key byte
// (clear, count, prefix sum, scatter from the end) and streams out the run.
// ----------------------------------------------------------------------------
`default_nettype none
module lrsb_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_valid,
  output logic                     q_take,
  input  wire lrsb_pkg::item_t     q_item,
  input  wire [lrsb_pkg::KB_W-1:0] kb_cfg,
  input  wire                      desc_cfg,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [lrsb_pkg::KEY_W-1:0] out_sorted_key,
  output logic [lrsb_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                     out_last_out
);
  import lrsb_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_CNT   = 8'b0000_0100,
    S_CNTW  = 8'b0000_1000,
    S_PSUM  = 8'b0001_0000,
    S_SCAT  = 8'b0010_0000,
    S_SCATW = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt;

  // stores: bank 0 = a, bank 1 = b; one write and one registered read a cycle
  logic [KEY_W+TAG_W-1:0] store_a [MAX_N];
  logic [KEY_W+TAG_W-1:0] store_b [MAX_N];
  logic [CNT_W-1:0]       counts  [RADIX];

  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;         // element index
  logic [DIG_W-1:0] d_r, d_nxt;         // digit index for clear / prefix sum
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [2:0]       pass_r, pass_nxt;
  logic [2:0]       lastp_r, lastp_nxt;
  logic             src_r, src_nxt;     // bank holding current data
  logic             desc_r, desc_nxt;
  logic [KEY_W-1:0] mask_r, mask_nxt;
  logic             rd_last_r;          // element just read was the final one

  logic [KEY_W+TAG_W-1:0] rd_a_r, rd_b_r, rd_data;
  logic [KEY_W-1:0]       rd_key;
  logic [DIG_W-1:0]       rd_dig;
  logic [CNT_W-1:0]       cnt_rd_r, cnt_dec;

  logic                   obuf_v_r;
  logic [KEY_W-1:0]       obuf_k_r;
  logic [TAG_W-1:0]       obuf_t_r;
  logic                   obuf_l_r;
  logic                   out_pend_r;   // a read for output is in flight

  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_a, wr_b;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W+TAG_W-1:0] wr_data;
  logic             cnt_we;
  logic [DIG_W-1:0] cnt_wa;
  logic [CNT_W-1:0] cnt_wd;
  logic [DIG_W-1:0] cnt_ra;
  logic [3:0]       kb_eff;
  logic             obuf_free;
  logic             out_fire;
  logic             load_fire;

  assign rd_data = src_r ? rd_b_r : rd_a_r;
  assign rd_key  = rd_data[KEY_W+TAG_W-1:TAG_W];
  assign rd_dig  = rd_key[{pass_r, 3'b000} +: DIG_W];
  assign cnt_dec = cnt_rd_r - CNT_W'(1);

  assign out_fire  = obuf_v_r && !out_stall;
  assign obuf_free = !obuf_v_r || !out_stall;
  assign out_valid = obuf_v_r;
  assign out_sorted_key = obuf_k_r;
  assign out_sorted_tag = obuf_t_r;
  assign out_last_out   = obuf_l_r;

  assign q_take    = (st_r == S_LOAD);
  assign load_fire = q_valid && q_take;

  always_comb begin
    if (kb_cfg == 4'd0) kb_eff = 4'd1;
    else if (kb_cfg > 4'(MAX_KEY_BYTES)) kb_eff = 4'(MAX_KEY_BYTES);
    else kb_eff = kb_cfg;
  end

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    pass_nxt  = pass_r;
    lastp_nxt = lastp_r;
    src_nxt   = src_r;
    desc_nxt  = desc_r;
    mask_nxt  = mask_r;
    rd_addr   = i_r;
    rd_en     = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    wr_addr   = n_r[IDX_W-1:0];
    wr_data   = {q_item.key, q_item.tag};
    cnt_we    = 1'b0;
    cnt_wa    = d_r;
    cnt_wd    = '0;
    cnt_ra    = d_r;
    case (st_r)
      S_LOAD: begin
        if (load_fire) begin
          if (n_r != CNT_W'(MAX_N)) begin
            wr_a  = 1'b1;
            n_nxt = n_r + CNT_W'(1);
          end
          if (q_item.last) begin
            src_nxt   = 1'b0;
            pass_nxt  = 3'd0;
            lastp_nxt = 3'(kb_eff - 4'd1);
            desc_nxt  = desc_cfg;
            mask_nxt  = (kb_eff >= 4'd8) ? '1 :
                        ((KEY_W'(1) << {kb_eff[2:0], 3'b000}) - KEY_W'(1));
            d_nxt     = '0;
            st_nxt    = S_CLR;
          end
        end
      end
      S_CLR: begin
        cnt_we = 1'b1;
        cnt_wd = '0;
        d_nxt  = d_r + DIG_W'(1);
        if (d_r == DIG_W'(RADIX - 1)) begin
          i_nxt  = '0;
          st_nxt = (n_r == '0) ? S_OUT : S_CNT;
          d_nxt  = '0;
          acc_nxt = '0;
        end
      end
      S_CNT: begin
        // read element i; its digit is counted in S_CNTW
        rd_en   = 1'b1;
        rd_addr = i_r;
        st_nxt  = S_CNTW;
      end
      S_CNTW: begin
        // count read is registered: wait here for it, then write it back incremented
        cnt_ra = rd_dig;
        st_nxt = S_CNTW;
      end
      S_PSUM: begin
        // in: cnt_rd_r holds counts[d]; write running total
        cnt_we  = 1'b1;
        cnt_wa  = d_r;
        cnt_wd  = acc_r + cnt_rd_r;
        acc_nxt = acc_r + cnt_rd_r;
        d_nxt   = d_r + DIG_W'(1);
        cnt_ra  = d_r + DIG_W'(1);
        if (d_r == DIG_W'(RADIX - 1)) begin
          i_nxt  = IDX_W'(n_r - CNT_W'(1));
          st_nxt = S_SCAT;
        end
      end
      S_SCAT: begin
        rd_en   = 1'b1;
        rd_addr = i_r;
        st_nxt  = S_SCATW;
      end
      S_SCATW: begin
        cnt_ra = rd_dig;
        st_nxt = S_SCATW;
      end
      S_OUT: begin
        if (obuf_free && !out_pend_r && !rd_last_r) begin
          rd_en   = 1'b1;
          rd_addr = desc_r ? IDX_W'(n_r - CNT_W'(1) - CNT_W'(i_r)) : i_r;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  // sub-phase counter for the read-count-write sequences
  logic [1:0] ph_r, ph_nxt;
  logic       seq_done;
  always_comb begin
    ph_nxt   = ph_r;
    seq_done = 1'b0;
    if (st_r == S_CNTW || st_r == S_SCATW) begin
      ph_nxt = ph_r + 2'd1;
      if (ph_r == 2'd1) begin
        ph_nxt   = 2'd0;
        seq_done = 1'b1;
      end
    end
  end

  // final state decisions for the count / scatter sequences and output stream
  state_t     st_fin;
  logic [IDX_W-1:0] i_fin;
  logic [7:0] d_fin;
  logic [2:0] pass_fin;
  logic       src_fin;
  logic       cnt_we_f;
  logic [DIG_W-1:0] cnt_wa_f, cnt_ra_f;
  logic [CNT_W-1:0] cnt_wd_f;
  logic       wa_f, wb_f;
  logic [IDX_W-1:0] waddr_f;
  logic [KEY_W+TAG_W-1:0] wdata_f;
  logic [CNT_W-1:0] n_fin;
  logic       ob_load;

  always_comb begin
    st_fin   = st_nxt;
    i_fin    = i_nxt;
    d_fin    = d_nxt;
    pass_fin = pass_nxt;
    src_fin  = src_nxt;
    n_fin    = n_nxt;
    cnt_we_f = cnt_we;
    cnt_wa_f = cnt_wa;
    cnt_wd_f = cnt_wd;
    cnt_ra_f = cnt_ra;
    wa_f     = wr_a;
    wb_f     = wr_b;
    waddr_f  = wr_addr;
    wdata_f  = wr_data;
    ob_load  = 1'b0;
    case (st_r)
      S_CNTW: begin
        cnt_ra_f = rd_dig;
        if (seq_done) begin
          // cnt_rd_r now holds counts[dig]
          cnt_we_f = 1'b1;
          cnt_wa_f = rd_dig;
          cnt_wd_f = cnt_rd_r + CNT_W'(1);
          if (CNT_W'(i_r) == n_r - CNT_W'(1)) begin
            st_fin   = S_PSUM;
            d_fin    = '0;
          end else begin
            i_fin  = i_r + IDX_W'(1);
            st_fin = S_CNT;
          end
        end else begin
          st_fin = S_CNTW;
        end
      end
      S_PSUM: begin
        if (d_r == DIG_W'(RADIX - 1)) cnt_ra_f = d_r;
      end
      S_SCATW: begin
        cnt_ra_f = rd_dig;
        if (seq_done) begin
          cnt_we_f = 1'b1;
          cnt_wa_f = rd_dig;
          cnt_wd_f = cnt_dec;
          waddr_f  = cnt_dec[IDX_W-1:0];
          wdata_f  = rd_data;
          wa_f     = src_r;
          wb_f     = !src_r;
          if (i_r == '0) begin
            src_fin = !src_r;
            if (pass_r == lastp_r) begin
              st_fin = S_OUT;
              i_fin  = '0;
            end else begin
              pass_fin = pass_r + 3'd1;
              d_fin    = '0;
              st_fin   = S_CLR;
            end
          end else begin
            i_fin  = i_r - IDX_W'(1);
            st_fin = S_SCAT;
          end
        end else begin
          st_fin = S_SCATW;
        end
      end
      S_OUT: begin
        if (out_pend_r) ob_load = 1'b1;
        if (rd_en) i_fin = i_r + IDX_W'(1);
        if (n_r == '0) begin
          st_fin = S_LOAD;
        end else if (out_fire && obuf_l_r) begin
          st_fin = S_LOAD;
          n_fin  = '0;
          i_fin  = '0;
        end
      end
      default: ;
    endcase
  end

  // prefix-sum read address: the first digit must be preloaded on entry
  logic [DIG_W-1:0] cnt_ra_use;
  always_comb begin
    cnt_ra_use = cnt_ra_f;
    if (st_r == S_CNTW && st_fin == S_PSUM) cnt_ra_use = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_LOAD;
      n_r        <= '0;
      i_r        <= '0;
      d_r        <= '0;
      acc_r      <= '0;
      pass_r     <= '0;
      lastp_r    <= '0;
      src_r      <= 1'b0;
      desc_r     <= 1'b0;
      ph_r       <= '0;
      obuf_v_r   <= 1'b0;
      out_pend_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      st_r    <= st_fin;
      n_r     <= n_fin;
      i_r     <= i_fin;
      d_r     <= d_fin;
      acc_r   <= acc_nxt;
      pass_r  <= pass_fin;
      lastp_r <= lastp_nxt;
      src_r   <= src_fin;
      desc_r  <= desc_nxt;
      ph_r    <= ph_nxt;
      out_pend_r <= (st_r == S_OUT) && rd_en;
      if (st_r == S_OUT && rd_en)
        rd_last_r <= (CNT_W'(i_r) == n_r - CNT_W'(1));
      else if (st_r != S_OUT)
        rd_last_r <= 1'b0;
      if (ob_load) obuf_v_r <= 1'b1;
      else if (out_fire) obuf_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (ob_load) begin
      obuf_k_r <= rd_key & mask_r;
      obuf_t_r <= rd_data[TAG_W-1:0];
      obuf_l_r <= rd_last_r;
    end
  end

  // ping-pong stores
  always_ff @(posedge clk) begin
    if (wa_f) store_a[waddr_f] <= wdata_f;
    if (rd_en) rd_a_r <= store_a[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (wb_f) store_b[waddr_f] <= wdata_f;
    if (rd_en) rd_b_r <= store_b[rd_addr];
  end

  // digit count memory; a read of the entry being written returns the new value
  always_ff @(posedge clk) begin
    if (cnt_we_f) counts[cnt_wa_f] <= cnt_wd_f;
    if (cnt_we_f && cnt_wa_f == cnt_ra_use) cnt_rd_r <= cnt_wd_f;
    else cnt_rd_r <= counts[cnt_ra_use];
  end
endmodule
`default_nettype wire

/* hdl/lsd_radix_sort_bytes.sv */
// ----------------------------------------------------------------------------
// lsd_radix_sort_bytes
// Top level of the base-256 LSD radix sorter for tagged keys.
// ----------------------------------------------------------------------------
// Beats are loaded one per cycle, while the core is in its load state, into
// a 64-entry store until one marked last arrives (beats beyond 64 are
// dropped). The core then runs key_bytes counting-sort passes (zero counts as
// one, above eight as eight); each pass clears the counts, counts the digits,
// forms the prefix sum and scatters from the end, on memories with one read
// and one write a cycle. The run of n results then streams out; a store read
// for output waits until the one before it has reached the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lsd_radix_sort_bytes (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire [0:0]                  cfg_index,
  input  wire [lrsb_pkg::KB_W-1:0]   cfg_data,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [lrsb_pkg::KEY_W-1:0]  in_key_value,
  input  wire [lrsb_pkg::TAG_W-1:0]  in_tag,
  input  wire                        in_last_in,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [lrsb_pkg::KEY_W-1:0] out_sorted_key,
  output logic [lrsb_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                       out_last_out
);
  import lrsb_pkg::*;

  logic [KB_W-1:0] kb_r;
  logic            desc_r;
  item_t           in_item, q_item;
  logic            q_valid, q_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r   <= KB_W'(MAX_KEY_BYTES);
      desc_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_BYTES:  kb_r   <= cfg_data;
        REG_DESCENDING: desc_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item = '{key: in_key_value, tag: in_tag, last: in_last_in};

  lrsb_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_valid, .q_take, .q_item
  );

  lrsb_core u_core (
    .clk, .rst_n, .q_valid, .q_take, .q_item,
    .kb_cfg(kb_r), .desc_cfg(desc_r),
    .out_valid, .out_stall, .out_sorted_key, .out_sorted_tag, .out_last_out
  );
endmodule
`default_nettype wire

/* hdl/lrsb_checker.sv */
// ----------------------------------------------------------------------------
// lrsb_checker
// Port-level checks for the radix sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lrsb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [63:0] out_sorted_key,
  input wire        out_last_out,
  input wire        in_valid,
  input wire        in_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_key))
    else $error("result dropped under stall");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_out |=> !out_valid)
    else $error("result right after end of run");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input beat withdrawn");
endmodule

bind lsd_radix_sort_bytes lrsb_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_sorted_key, .out_last_out,
  .in_valid, .in_stall
);
`default_nettype wire

/* tb/lsd_radix_sort_bytes_chk.sv */
// ----------------------------------------------------------------------------
// lsd_radix_sort_bytes_chk
// Watches both channels of the radix sorter, predicts each sorted run from
// the loaded beats and compares the output beats field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module lsd_radix_sort_bytes_chk (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire [0:0]                  cfg_index,
  input  wire [lrsb_pkg::KB_W-1:0]   cfg_data,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire [lrsb_pkg::KEY_W-1:0]  in_key_value,
  input  wire [lrsb_pkg::TAG_W-1:0]  in_tag,
  input  wire                        in_last_in,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire [lrsb_pkg::KEY_W-1:0]  out_sorted_key,
  input  wire [lrsb_pkg::TAG_W-1:0]  out_sorted_tag,
  input  wire                        out_last_out,
  output int                         fail_count,
  output int                         pending_count
);
  import lrsb_pkg::*;

  item_t        loaded_q[$];
  item_t        sorted_q[$];
  logic [3:0]   key_len;
  logic         desc_order;

  // Stable sort on the low kb bytes, then optional reversal.
  task automatic sort_run(input int kb);
    item_t       run[$];
    item_t       bucket[256][$];
    item_t       it;
    logic [63:0] mask;
    int          n;
    run = loaded_q;
    n = run.size();
    for (int p = 0; p < kb; p++) begin
      for (int d = 0; d < 256; d++) bucket[d].delete();
      foreach (run[i]) bucket[run[i].key[8*p +: 8]].push_back(run[i]);
      run.delete();
      for (int d = 0; d < 256; d++)
        for (int j = 0; j < bucket[d].size(); j++) run.push_back(bucket[d][j]);
    end
    mask = (kb >= 8) ? '1 : ((64'd1 << (8 * kb)) - 1);
    for (int i = 0; i < n; i++) begin
      it = run[desc_order ? n - 1 - i : i];
      it.key &= mask;
      it.last = (i == n - 1);
      sorted_q.push_back(it);
    end
    loaded_q.delete();
  endtask

  always @(posedge clk) begin
    int   kb;
    item_t exp_item;
    if (!rst_n) begin
      key_len       <= 4'd8;
      desc_order    <= 1'b0;
      fail_count    <= 0;
      pending_count <= 0;
      loaded_q.delete();
      sorted_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_BYTES) key_len <= cfg_data;
        else if (cfg_index == REG_DESCENDING) desc_order <= cfg_data[0];
      end
      if (in_valid && !in_stall) begin
        if (loaded_q.size() < MAX_N) loaded_q.push_back('{in_key_value, in_tag, 1'b0});
        if (in_last_in) begin
          kb = (key_len == 0) ? 1 : (key_len > MAX_KEY_BYTES ? MAX_KEY_BYTES : key_len);
          sort_run(kb);
        end
      end
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat key=%h tag=%h", out_sorted_key,
                                        out_sorted_tag);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = sorted_q.pop_front();
          if (exp_item.key !== out_sorted_key || exp_item.tag !== out_sorted_tag ||
              exp_item.last !== out_last_out) begin
            if (fail_count < 10)
              $display("mismatch: exp key=%h tag=%h last=%b, got key=%h tag=%h last=%b",
                       exp_item.key, exp_item.tag, exp_item.last,
                       out_sorted_key, out_sorted_tag, out_last_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= sorted_q.size();
    end
  end
endmodule
`default_nettype wire

/* tb/lsd_radix_sort_bytes_tb.sv */
// ----------------------------------------------------------------------------
// lsd_radix_sort_bytes_tb
// Drives key sets through the radix sorter across key lengths and both
// orders, with random gaps and a long output hold-off; verdict at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module lsd_radix_sort_bytes_tb;
  import lrsb_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [0:0]           cfg_index;
  logic [KB_W-1:0]      cfg_data;
  logic                 in_valid;
  wire                  in_stall;
  logic [KEY_W-1:0]     in_key_value;
  logic [TAG_W-1:0]     in_tag;
  logic                 in_last_in;
  wire                  out_valid;
  logic                 out_stall;
  wire  [KEY_W-1:0]     out_sorted_key;
  wire  [TAG_W-1:0]     out_sorted_tag;
  wire                  out_last_out;
  int                   fail_count;
  int                   pending_count;
  int                   idle_cycles;
  bit                   hold_off;
  bit                   no_gaps;

  lsd_radix_sort_bytes i_dut (.*);
  lsd_radix_sort_bytes_chk i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Random keys mostly reuse a few byte values so equal digits and keys occur.
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: k = {$urandom_range(0, 3), $urandom_range(0, 3)};
      2: k = {8{8'($urandom_range(0, 2) * 8'h7f)}};
      default: k = {$urandom, 24'h0, 8'($urandom_range(0, 3))};
    endcase
    return k;
  endfunction

  task automatic send_beat(input logic [63:0] k, input logic [15:0] t, input logic l);
    in_valid     <= 1'b1;
    in_key_value <= k;
    in_tag       <= t;
    in_last_in   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!no_gaps) begin
      repeat (gap_len()) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_set(input int n);
    for (int i = 0; i < n; i++) send_beat(pick_key(), 16'($urandom), i == n - 1);
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end else if (no_gaps || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_key_value = '0; in_tag = '0; in_last_in = 1'b0;
    hold_off = 1'b0; no_gaps = 1'b0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, equal keys for stability, single item.
    send_beat('1, 16'hffff, 1'b0);
    send_beat('0, 16'h0000, 1'b0);
    send_beat(64'h0100, 16'h0001, 1'b0);
    send_beat(64'h0100, 16'h0002, 1'b0);
    send_beat(64'h8000_0000_0000_0001, 16'h0003, 1'b1);
    send_beat(64'h55, 16'h1234, 1'b1);
    quiesce();
    write_reg(REG_DESCENDING, 4'd1);
    write_reg(REG_KEY_BYTES, 4'd1);
    send_beat(64'haaaa_5555_aaaa_5555, 16'h0a0a, 1'b0);
    send_beat(64'h0000_0000_0000_0055, 16'h0b0b, 1'b0);
    send_beat(64'hffff_0000_ffff_0055, 16'h0c0c, 1'b1);
    quiesce();
    // Out-of-range key lengths: zero and above eight.
    write_reg(REG_KEY_BYTES, 4'd0);
    send_beat(64'h1234, 16'h1, 1'b0);
    send_beat(64'h0034, 16'h2, 1'b1);
    quiesce();
    write_reg(REG_KEY_BYTES, 4'd15);
    write_reg(REG_DESCENDING, 4'd0);
    random_set(3);
    quiesce();

    // Full store with overflow beats, back-to-back under a long hold-off.
    write_reg(REG_KEY_BYTES, 4'd2);
    no_gaps  = 1'b1;
    hold_off = 1'b1;
    random_set(MAX_N + 3);
    no_gaps = 1'b0;
    quiesce();

    // Random sets of small size across settings.
    for (int s = 0; s < 8; s++) begin
      write_reg(REG_KEY_BYTES, 4'($urandom_range(0, 15)));
      write_reg(REG_DESCENDING, 4'($urandom_range(0, 1)));
      random_set($urandom_range(1, 6));
      quiesce();
    end
    write_reg(REG_KEY_BYTES, 4'd8);
    random_set(8);
    quiesce();
    repeat (50) @(posedge clk);

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
